[design/bssm_pkg.sv]
// ----------------------------------------------------------------------------
// bssm_pkg
// Shared types, constants and the arctangent table for the best-sample
// selector with circular mean.
// ----------------------------------------------------------------------------
package bssm_pkg;

	localparam int LIST_DEPTH_DEF = 8;
	localparam int SIDE_COUNT_DEF = 4;
	localparam int PASSES         = 16;

	// Command codes.
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_ADD     = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// CORDIC formats: angles in 1/25600 degree, vectors in Q2.14.
	localparam logic signed [17:0] CORDIC_START = 18'sd9949;
	localparam logic signed [25:0] QUARTER_Z    = 26'sd2304000;
	localparam logic signed [25:0] HALF_TURN    = 26'sd18000;

	typedef struct packed {
		logic signed [15:0] err;
		logic signed [15:0] yaw;
	} entry_t;

	// Payload of one input beat.
	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] px_err;
		logic signed [15:0] yaw_cdeg;
	} in_beat_t;

	// Payload of one result beat.
	typedef struct packed {
		logic               complete;
		logic [3:0]         left_entries;
		logic [3:0]         right_entries;
		logic               mean_valid;
		logic signed [15:0] mean_yaw_cdeg;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;      // empty both lists
		logic load;       // capture the incoming sample
		logic shift_step; // one step of the insertion walk
		logic sc_init;    // start a sin/cos for the current slot
		logic sc_step;    // one rotation pass
		logic sc_acc;     // add the vector to the sums
		logic at_init;    // start the arctangent
		logic at_step;    // one vectoring pass
		logic finish;     // register the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic insert_done;
	} status_t;

	function automatic logic signed [25:0] atan_entry(input logic [3:0] i);
		logic signed [25:0] r;
		begin
			case (i)
				4'd0:  r = 26'sd1152000;
				4'd1:  r = 26'sd680065;
				4'd2:  r = 26'sd359328;
				4'd3:  r = 26'sd182400;
				4'd4:  r = 26'sd91554;
				4'd5:  r = 26'sd45822;
				4'd6:  r = 26'sd22916;
				4'd7:  r = 26'sd11459;
				4'd8:  r = 26'sd5730;
				4'd9:  r = 26'sd2865;
				4'd10: r = 26'sd1432;
				4'd11: r = 26'sd716;
				4'd12: r = 26'sd358;
				4'd13: r = 26'sd179;
				4'd14: r = 26'sd90;
				default: r = 26'sd45;
			endcase
			return r;
		end
	endfunction

endpackage

[design/bssm_stream_if.sv]
// ----------------------------------------------------------------------------
// bssm_stream_if
// Valid/ready channel carrying a payload of parameterised type.
// ----------------------------------------------------------------------------
interface bssm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/bssm_ctrl.sv]
// ----------------------------------------------------------------------------
// bssm_ctrl
// Controller: sequences the insertion walk, the sin/cos passes over the
// selected slots and the final arctangent, then presents the result.
// ----------------------------------------------------------------------------
module bssm_ctrl #(
	parameter int SIDE_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_cmd,
	input  bssm_pkg::status_t st,
	output bssm_pkg::cmd_t    cmd,
	output logic [$clog2(2*SIDE_COUNT+1)-1:0] slot,
	output logic [3:0]        pass,
	output logic              out_valid,
	input  logic              out_ready
);
	import bssm_pkg::*;

	localparam int SW = $clog2(2*SIDE_COUNT+1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(2*SIDE_COUNT-1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_SCI  = 3'd2;
	localparam logic [2:0] S_SC   = 3'd3;
	localparam logic [2:0] S_AT   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]    state_q;
	logic [SW-1:0] slot_q;
	logic [3:0]    pass_q;
	logic          accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign slot      = slot_q;
	assign pass      = pass_q;

	// Command decode per state.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.clear = accept && (in_cmd == CMD_CLEAR);
				cmd.load  = accept && (in_cmd == CMD_ADD);
				cmd.at_init = 1'b0;
			end
			S_INS:  cmd.shift_step = 1'b1;
			S_SCI:  cmd.sc_init = 1'b1;
			S_SC: begin
				cmd.sc_step = 1'b1;
				cmd.sc_acc  = (pass_q == 4'd15);
			end
			S_AT: begin
				cmd.at_init = (pass_q == 4'd0) && (slot_q == '0);
				cmd.at_step = 1'b1;
			end
			S_DONE: cmd.finish = 1'b1;
			S_OUT:  ;
			default: ;
		endcase
	end

	// State register and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q  <= '0;
			pass_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					slot_q <= '0;
					pass_q <= '0;
					if (accept) begin
						if (in_cmd == CMD_ADD) state_q <= S_INS;
						else if (in_cmd == CMD_COMPUTE) state_q <= S_SCI;
						else state_q <= S_DONE;
					end
				end
				S_INS: if (st.insert_done) state_q <= S_DONE;
				S_SCI: begin
					pass_q  <= '0;
					state_q <= S_SC;
				end
				S_SC: begin
					pass_q <= pass_q + 4'd1;
					if (pass_q == 4'd15) begin
						if (slot_q == LAST_SLOT) begin
							slot_q  <= '0;
							state_q <= S_AT;
						end else begin
							slot_q  <= slot_q + SW'(1);
							state_q <= S_SCI;
						end
					end
				end
				S_AT: begin
					// slot_q marks that the initial turn has been taken.
					if (slot_q == '0) slot_q <= SW'(1);
					else begin
						pass_q <= pass_q + 4'd1;
						if (pass_q == 4'd15) state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The input side is closed while work is in flight.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("ready while a result is pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SC |-> slot_q <= LAST_SLOT)
		else $error("slot out of range");
endmodule

[design/bssm_datapath.sv]
// ----------------------------------------------------------------------------
// bssm_datapath
// Datapath: the two sorted lists, the insertion shifter, the shared CORDIC
// unit for sin/cos and arctangent, and the result register.
// ----------------------------------------------------------------------------
module bssm_datapath #(
	parameter int LIST_DEPTH = 8,
	parameter int SIDE_COUNT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bssm_pkg::cmd_t      cmd,
	output bssm_pkg::status_t   st,
	input  logic [$clog2(2*SIDE_COUNT+1)-1:0] slot,
	input  logic [3:0]          pass,
	input  logic signed [15:0]  in_err,
	input  logic signed [15:0]  in_yaw,
	input  logic [1:0]          res_cmd,
	output logic                complete,
	output logic [3:0]          left_entries,
	output logic [3:0]          right_entries,
	output logic                mean_valid,
	output logic signed [15:0]  mean_yaw_cdeg
);
	import bssm_pkg::*;

	localparam int FW = $clog2(LIST_DEPTH+1);
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int SW = $clog2(2*SIDE_COUNT+1);

	entry_t        left_q  [LIST_DEPTH];
	entry_t        right_q [LIST_DEPTH];
	logic [FW-1:0] lfill_q, rfill_q;
	logic          zleft_q;

	// Insertion walk state.
	logic          side_q;      // 1: right list
	logic          act_q;       // sample will be placed
	logic [FW-1:0] k_q;
	entry_t        smp_q;

	function automatic logic [15:0] mag(input logic signed [15:0] e);
		return e[15] ? 16'(-e) : 16'(e);
	endfunction

	// Side choice and full-list test for the incoming sample.
	logic          go_right;
	logic [FW-1:0] fill_sel;
	entry_t        worst;
	always_comb begin
		if (in_err < 0) go_right = 1'b0;
		else if (in_err > 0) go_right = 1'b1;
		else go_right = !((lfill_q < rfill_q) || ((lfill_q == rfill_q) && zleft_q));
		fill_sel = go_right ? rfill_q : lfill_q;
		worst    = go_right ? right_q[IW'(LIST_DEPTH-1)] : left_q[IW'(LIST_DEPTH-1)];
	end

	// Neighbour in front of the walk position.
	entry_t  prev;
	logic    k_nz;
	always_comb begin
		k_nz = (k_q != '0);
		prev = side_q ? right_q[IW'(k_q - FW'(1))] : left_q[IW'(k_q - FW'(1))];
	end
	logic walk_move;
	assign walk_move = act_q && k_nz && (mag(smp_q.err) < mag(prev.err));
	assign st.insert_done = !walk_move;

	// Lists and fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				left_q[i]  <= '0;
				right_q[i] <= '0;
			end
			lfill_q <= '0;
			rfill_q <= '0;
			zleft_q <= 1'b1;
			side_q  <= 1'b0;
			act_q   <= 1'b0;
			k_q     <= '0;
			smp_q   <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				left_q[i]  <= '0;
				right_q[i] <= '0;
			end
			lfill_q <= '0;
			rfill_q <= '0;
			zleft_q <= 1'b1;
		end else if (cmd.load) begin
			side_q <= go_right;
			smp_q  <= '{err: in_err, yaw: in_yaw};
			if (in_err == 0) zleft_q <= go_right;
			if (fill_sel < FW'(LIST_DEPTH)) begin
				act_q <= 1'b1;
				k_q   <= fill_sel;
				if (go_right) rfill_q <= rfill_q + FW'(1);
				else lfill_q <= lfill_q + FW'(1);
			end else begin
				act_q <= mag(in_err) < mag(worst.err);
				k_q   <= FW'(LIST_DEPTH-1);
			end
		end else if (cmd.shift_step && act_q) begin
			if (walk_move) begin
				if (side_q) right_q[IW'(k_q)] <= prev;
				else left_q[IW'(k_q)] <= prev;
				k_q <= k_q - FW'(1);
			end else begin
				if (side_q) right_q[IW'(k_q)] <= smp_q;
				else left_q[IW'(k_q)] <= smp_q;
				act_q <= 1'b0;
			end
		end
	end

	// Yaw of the slot being converted: even slots left, odd slots right.
	logic signed [15:0] slot_yaw;
	logic [SW-1:0]      idx;
	always_comb begin
		idx = slot >> 1;
		slot_yaw = '0;
		if (int'(idx) < LIST_DEPTH)
			slot_yaw = slot[0] ? right_q[IW'(idx)].yaw : left_q[IW'(idx)].yaw;
	end

	// Wrap, fold into the right half plane.
	logic signed [17:0] wa, fa;
	logic               flip;
	always_comb begin
		wa = 18'(slot_yaw);
		if (wa >= 18'sd18000) wa = wa - 18'sd36000;
		else if (wa < -18'sd18000) wa = wa + 18'sd36000;
		flip = 1'b0;
		fa = wa;
		if (wa > 18'sd9000) begin
			fa = wa - 18'sd18000;
			flip = 1'b1;
		end else if (wa < -18'sd9000) begin
			fa = wa + 18'sd18000;
			flip = 1'b1;
		end
	end

	// Shared CORDIC registers.
	logic signed [25:0] x_q, y_q, z_q;
	logic               flip_q;
	logic signed [25:0] sx_q, sy_q;
	logic signed [25:0] dx, dy, xn, yn, zn, at;
	logic               rot_pos;
	always_comb begin
		dx = y_q >>> pass;
		dy = x_q >>> pass;
		at = atan_entry(pass);
		rot_pos = cmd.sc_step ? (z_q >= 0) : (y_q < 0);
		if (rot_pos) begin
			xn = x_q - dx; yn = y_q + dy; zn = z_q - at;
		end else begin
			xn = x_q + dx; yn = y_q - dy; zn = z_q + at;
		end
	end

	// Final rounding and clamp of the angle.
	logic signed [25:0] zr;
	logic signed [15:0] ang;
	always_comb begin
		zr = (z_q + 26'sd128) >>> 8;
		if (zr > HALF_TURN) ang = 16'sd18000;
		else if (zr < -HALF_TURN) ang = -16'sd18000;
		else ang = zr[15:0];
	end

	logic [FW:0] tot;
	assign tot = {1'b0, lfill_q} + {1'b0, rfill_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; z_q <= '0; flip_q <= 1'b0;
			sx_q <= '0; sy_q <= '0;
			complete <= 1'b0; left_entries <= '0; right_entries <= '0;
			mean_valid <= 1'b0; mean_yaw_cdeg <= '0;
		end else begin
			if (cmd.sc_init) begin
				x_q <= 26'(CORDIC_START);
				y_q <= '0;
				z_q <= 26'(fa) * 26'sd256;
				flip_q <= flip;
				if (slot == '0) begin
					sx_q <= '0;
					sy_q <= '0;
				end
			end else if (cmd.sc_step) begin
				x_q <= xn; y_q <= yn; z_q <= zn;
				if (cmd.sc_acc) begin
					sx_q <= sx_q + (flip_q ? -xn : xn);
					sy_q <= sy_q + (flip_q ? -yn : yn);
				end
			end else if (cmd.at_init) begin
				// Turn by a quarter when x is negative.
				if (sx_q < 0) begin
					if (sy_q >= 0) begin
						x_q <= sy_q; y_q <= -sx_q; z_q <= QUARTER_Z;
					end else begin
						x_q <= -sy_q; y_q <= sx_q; z_q <= -QUARTER_Z;
					end
				end else begin
					x_q <= sx_q; y_q <= sy_q; z_q <= '0;
				end
			end else if (cmd.at_step) begin
				x_q <= xn; y_q <= yn; z_q <= zn;
			end
			if (cmd.finish) begin
				complete <= (int'(tot) >= LIST_DEPTH) &&
					(int'(lfill_q) >= SIDE_COUNT) &&
					(int'(rfill_q) >= SIDE_COUNT);
				left_entries  <= 4'(lfill_q);
				right_entries <= 4'(rfill_q);
				mean_valid    <= (res_cmd == CMD_COMPUTE);
				mean_yaw_cdeg <= (res_cmd == CMD_COMPUTE && (sx_q != 0 || sy_q != 0)) ?
					ang : 16'sd0;
			end
		end
	end

	a_fill_l: assert property (@(posedge clk) disable iff (!arst_n)
		lfill_q <= FW'(LIST_DEPTH)) else $error("left fill overflow");
	a_fill_r: assert property (@(posedge clk) disable iff (!arst_n)
		rfill_q <= FW'(LIST_DEPTH)) else $error("right fill overflow");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clear |=> (lfill_q >= $past(lfill_q)) && (rfill_q >= $past(rfill_q)))
		else $error("fill fell without a clear");
endmodule

[design/best_sample_selector_circular_mean.sv]
// ----------------------------------------------------------------------------
// best_sample_selector_circular_mean
// Keeps two sorted lists of best samples and returns their circular mean yaw.
// ----------------------------------------------------------------------------
// Usage: one input channel carries beats of {cmd, px_err, yaw_cdeg}; one
// output channel returns one beat per command with the list counts, the
// completeness flag and, for a compute command, the mean yaw.
// Clear goes from acceptance through the finish state to the result beat. Add
// walks the sample past each list entry of larger error magnitude, then finishes.
// Compute runs the shared CORDIC unit: a sin/cos for each of the 2*SIDE_COUNT
// yaws, then the arctangent, then the finish state. One command is in flight
// at a time; the next beat is taken in the cycle after the result beat has
// been taken. Reset empties both lists, zeroes the counts and makes a
// zero-error sample meeting equal fills go to the left list. While the
// receiver stalls the result beat holds and no new command is accepted.
// ----------------------------------------------------------------------------
module best_sample_selector_circular_mean #(
	parameter int LIST_DEPTH = bssm_pkg::LIST_DEPTH_DEF,
	parameter int SIDE_COUNT = bssm_pkg::SIDE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	bssm_stream_if.sink   in_ch,
	bssm_stream_if.source out_ch
);
	import bssm_pkg::*;

	localparam int SW = $clog2(2*SIDE_COUNT+1);

	cmd_t          cmd;
	status_t       st;
	logic [SW-1:0] slot;
	logic [3:0]    pass;
	logic [1:0]    cmd_q;
	logic          accept;

	assign accept = in_ch.valid && in_ch.ready;

	// Command of the item in flight, for the result fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmd_q <= CMD_CLEAR;
		else if (accept) cmd_q <= in_ch.data.cmd;
	end

	bssm_ctrl #(.SIDE_COUNT(SIDE_COUNT)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd),
		.st, .cmd, .slot, .pass,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);

	bssm_datapath #(.LIST_DEPTH(LIST_DEPTH), .SIDE_COUNT(SIDE_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .st, .slot, .pass,
		.in_err(in_ch.data.px_err), .in_yaw(in_ch.data.yaw_cdeg),
		.res_cmd(cmd_q),
		.complete(out_ch.data.complete),
		.left_entries(out_ch.data.left_entries),
		.right_entries(out_ch.data.right_entries),
		.mean_valid(out_ch.data.mean_valid),
		.mean_yaw_cdeg(out_ch.data.mean_yaw_cdeg)
	);

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready) else $error("second beat taken in flight");
	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.mean_valid |-> out_ch.data.mean_yaw_cdeg == 16'sd0)
		else $error("mean without compute");
	a_mean_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.data.mean_valid == (cmd_q == CMD_COMPUTE))
		else $error("mean flag mismatch");
endmodule
